// ===== hw/rtl/tof_corrected_hit_window_count_macros.svh =====
// Assertion macros for the hit window counter.
// Depends on clk_i and rst_ni being visible at the point of use.
`ifndef TOF_CORRECTED_HIT_WINDOW_COUNT_MACROS_SVH
`define TOF_CORRECTED_HIT_WINDOW_COUNT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TCHW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define TCHW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/tchw_pkg.sv =====
// Types and constants for the time-of-flight corrected hit window counter.
// No dependencies.
package tchw_pkg;

  localparam int unsigned PmtCountDef = 16384;
  localparam int unsigned MaxHitsDef  = 2048;
  localparam int unsigned CountW      = 12;
  localparam int unsigned TimeW       = 24;
  localparam int unsigned PosW        = 20;
  localparam int unsigned CableW      = 15;
  localparam int unsigned CfgDataW    = 20;

  localparam logic [20:0] TofRecip    = 21'd777323;
  localparam logic [15:0] WindowReset = 16'd800;

  localparam logic [1:0] CFG_WINDOW   = 2'd0;
  localparam logic [1:0] CFG_VERTEX_X = 2'd1;
  localparam logic [1:0] CFG_VERTEX_Y = 2'd2;
  localparam logic [1:0] CFG_VERTEX_Z = 2'd3;

  localparam logic CMD_GEOMETRY = 1'b0;
  localparam logic CMD_HIT      = 1'b1;

  typedef struct packed {
    logic                       command;
    logic [CableW-1:0]          cable_id;
    logic signed [PosW-1:0]     pmt_x;
    logic signed [PosW-1:0]     pmt_y;
    logic signed [PosW-1:0]     pmt_z;
    logic signed [TimeW-1:0]    hit_time;
    logic                       last_hit;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] window_count;
    logic              overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_TOF,
    ST_TOF2,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SC_I,
    ST_SC_IW,
    ST_SC_J,
    ST_SC_JW
  } state_e;

endpackage

// ===== hw/rtl/tof_corrected_hit_window_count.sv =====
// Top level: time-of-flight corrected hit window counter.
// Depends on tchw_pkg and tof_corrected_hit_window_count_macros.svh.
//
// Usage: an item is transferred at a clock edge with start_i high and busy_o
// low. Geometry items (command 0) write the sensor position table and leave
// busy_o low. Hit items look up the sensor, square the vertex offsets on a
// shared 21x21 multiplier, take a bit-serial square root, scale by the
// time-of-flight reciprocal on the same multiplier and insertion-sort the
// corrected time into the time buffer (one read and one write port).
// On the hit marked last, a two-pointer scan over the sorted buffer follows;
// result_valid_o then pulses for one cycle with the count and overflow flag.
// The receiver cannot stall. Configuration writes are taken only while idle
// (cfg_ready_o low while busy). Reset clears the hit count, overflow flag and
// configuration registers to defaults; the position table and time buffer
// are not cleared.
module tof_corrected_hit_window_count #(
  parameter int unsigned PMT_COUNT = tchw_pkg::PmtCountDef,
  parameter int unsigned MAX_HITS  = tchw_pkg::MaxHitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  tchw_pkg::in_item_t                item_i,
  output logic                              result_valid_o,
  output tchw_pkg::out_item_t               result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [tchw_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tchw_pkg::*;

  localparam int unsigned PaW  = (PMT_COUNT > 1) ? $clog2(PMT_COUNT) : 1;
  localparam int unsigned BaW  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned CntW = $clog2(MAX_HITS + 1);

  state_e state_q, state_d;
  in_item_t item_q;
  logic valid_q;

  logic [15:0]         window_q;
  logic signed [19:0]  vx_q, vy_q, vz_q;

  logic [59:0] pos_mem [PMT_COUNT];
  logic [59:0] pos_rd_q;
  logic [16:0] cab_m1;
  logic        cab_valid;
  logic [PaW-1:0] pos_addr;

  logic [TimeW-1:0] tm_mem [MAX_HITS];
  logic             tm_we;
  logic [BaW-1:0]   tm_waddr, tm_raddr;
  logic [TimeW-1:0] tm_wdata, tm_rd_q;

  logic [1:0]  sq_idx_q, sq_idx_d;
  logic [20:0] mul_a, mul_b;
  logic [41:0] prod_q, acc_q, acc_d, x_q, x_d, res_q, res_d, bit_q, bit_d, sq_sum;
  logic [TimeW-1:0] t_q, t_d, ti_q, ti_d;
  logic [CntW-1:0] k_q, k_d, cnt_q, cnt_d, i_q, i_d, j_q, j_d, best_q, best_d, span;
  logic ovf_q, ovf_d;
  logic res_valid_q, res_valid_d;
  out_item_t result_q, result_d;

  logic signed [20:0] dax;
  logic [20:0] dabs;
  logic [41:0] tof_full;
  logic [17:0] tof;
  logic signed [24:0] tdiff;
  logic signed [25:0] wdiff;
  logic accept;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o;
  assign cab_m1      = {2'b00, item_i.cable_id} - 17'd1;
  assign pos_addr    = cab_m1[PaW-1:0];
  assign cab_valid   = (item_i.cable_id != '0) && ({2'b00, item_i.cable_id} <= 17'(PMT_COUNT));
  assign span        = j_q - i_q;

  always_ff @(posedge clk_i) begin
    if (accept && item_i.command == CMD_GEOMETRY && cab_valid) begin
      pos_mem[pos_addr] <= {item_i.pmt_x, item_i.pmt_y, item_i.pmt_z};
    end
    if (accept) begin
      pos_rd_q <= pos_mem[pos_addr];
      item_q   <= item_i;
      valid_q  <= cab_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tm_we) begin
      tm_mem[tm_waddr] <= tm_wdata;
    end
    tm_rd_q <= tm_mem[tm_raddr];
  end

  always_comb begin
    unique case (sq_idx_q)
      2'd0:    dax = 21'(vx_q) - 21'($signed(pos_rd_q[59:40]));
      2'd1:    dax = 21'(vy_q) - 21'($signed(pos_rd_q[39:20]));
      default: dax = 21'(vz_q) - 21'($signed(pos_rd_q[19:0]));
    endcase
    dabs = dax[20] ? 21'(-dax) : 21'(dax);
  end

  assign mul_a    = (state_q == ST_TOF) ? res_q[20:0] : dabs;
  assign mul_b    = (state_q == ST_TOF) ? TofRecip : dabs;
  assign sq_sum   = res_q + bit_q;
  assign tof_full = prod_q + (42'd1 << 23);
  assign tof      = valid_q ? tof_full[41:24] : 18'd0;
  assign tdiff    = {item_q.hit_time[TimeW-1], item_q.hit_time} - {7'd0, tof};
  assign wdiff    = {tm_rd_q[TimeW-1], tm_rd_q[TimeW-1], tm_rd_q}
                  - {ti_q[TimeW-1], ti_q[TimeW-1], ti_q};

  always_comb begin
    state_d     = state_q;
    sq_idx_d    = sq_idx_q;
    acc_d       = acc_q;
    x_d         = x_q;
    res_d       = res_q;
    bit_d       = bit_q;
    t_d         = t_q;
    ti_d        = ti_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    res_valid_d = 1'b0;
    result_d    = result_q;
    tm_we       = 1'b0;
    tm_waddr    = k_q[BaW-1:0];
    tm_wdata    = t_q;
    tm_raddr    = k_q[BaW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept && item_i.command == CMD_HIT) begin
          sq_idx_d = 2'd0;
          acc_d    = '0;
          state_d  = ST_SQ;
        end
      end
      ST_SQ: begin
        sq_idx_d = sq_idx_q + 2'd1;
        if (sq_idx_q != 2'd0) begin
          acc_d = acc_q + prod_q;
        end
        if (sq_idx_q == 2'd3) begin
          x_d     = acc_q + prod_q;
          res_d   = '0;
          bit_d   = 42'd1 << 40;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (x_q >= sq_sum) begin
          x_d   = x_q - sq_sum;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = ST_TOF;
        end
      end
      ST_TOF: begin
        state_d = ST_TOF2;
      end
      ST_TOF2: begin
        if (tdiff[24] != tdiff[23]) begin
          t_d = {1'b1, {(TimeW-1){1'b0}}};
        end else begin
          t_d = tdiff[TimeW-1:0];
        end
        if (cnt_q == CntW'(MAX_HITS)) begin
          ovf_d = 1'b1;
          if (item_q.last_hit) begin
            i_d = '0; j_d = '0; best_d = '0;
            state_d = ST_SC_I;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          k_d     = cnt_q;
          state_d = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        tm_raddr = BaW'(k_q - CntW'(1));
        if (k_q == '0) begin
          tm_we = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (item_q.last_hit) begin
            i_d = '0; j_d = '0; best_d = '0;
            state_d = ST_SC_I;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        tm_we = 1'b1;
        if ($signed(tm_rd_q) > $signed(t_q)) begin
          tm_wdata = tm_rd_q;
          k_d      = k_q - CntW'(1);
          state_d  = ST_INS_RD;
        end else begin
          cnt_d = cnt_q + CntW'(1);
          if (item_q.last_hit) begin
            i_d = '0; j_d = '0; best_d = '0;
            state_d = ST_SC_I;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SC_I: begin
        tm_raddr = i_q[BaW-1:0];
        if (i_q == cnt_q) begin
          res_valid_d           = 1'b1;
          result_d.window_count = CountW'(best_q);
          result_d.overflow     = ovf_q;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          if (j_q < i_q) begin
            j_d = i_q;
          end
          state_d = ST_SC_IW;
        end
      end
      ST_SC_IW: begin
        ti_d    = tm_rd_q;
        state_d = ST_SC_J;
      end
      ST_SC_J: begin
        tm_raddr = j_q[BaW-1:0];
        if (j_q < cnt_q) begin
          state_d = ST_SC_JW;
        end else begin
          if (span > best_q) begin
            best_d = span;
          end
          i_d     = i_q + CntW'(1);
          state_d = ST_SC_I;
        end
      end
      ST_SC_JW: begin
        if (wdiff <= $signed({10'd0, window_q})) begin
          j_d     = j_q + CntW'(1);
          state_d = ST_SC_J;
        end else begin
          if (span > best_q) begin
            best_d = span;
          end
          i_d     = i_q + CntW'(1);
          state_d = ST_SC_I;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= mul_a * mul_b;
    sq_idx_q <= sq_idx_d;
    acc_q    <= acc_d;
    x_q      <= x_d;
    res_q    <= res_d;
    bit_q    <= bit_d;
    t_q      <= t_d;
    ti_q     <= ti_d;
    k_q      <= k_d;
    i_q      <= i_d;
    j_q      <= j_d;
    best_q   <= best_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      window_q    <= WindowReset;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_WINDOW:   window_q <= cfg_data_i[15:0];
          CFG_VERTEX_X: vx_q     <= cfg_data_i;
          CFG_VERTEX_Y: vy_q     <= cfg_data_i;
          CFG_VERTEX_Z: vz_q     <= cfg_data_i;
          default:      window_q <= window_q;
        endcase
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = result_q;

`include "tof_corrected_hit_window_count_macros.svh"

  `TCHW_ASSERT_IMP(a_result_when_idle, result_valid_o, !busy_o)
  `TCHW_ASSERT_NXT(a_result_one_cycle, result_valid_o, !result_valid_o)
  `TCHW_ASSERT_IMP(a_count_bounded, 1'b1, cnt_q <= CntW'(MAX_HITS))
  `TCHW_ASSERT_NXT(a_geometry_no_busy, accept && item_i.command == CMD_GEOMETRY, !busy_o)
  `TCHW_ASSERT_NXT(a_result_clears_count, result_valid_o, cnt_q == '0)

endmodule
